// File: hdl/fpbc_pkg.sv
// Shared constants and types for the frustum point/box cull block.
// No dependencies; used by every module under hdl/.
package fpbc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int NUM_PAIRS   = 8;
    localparam int NUM_PLANES  = 6;
    localparam int NUM_AXES    = 3;
    localparam int NUM_COEFS   = 4;

    localparam int SLOT_WIDTH  = 32;
    localparam int DATA_WIDTH  = 64;
    localparam int PAIR_IDX_W  = $clog2(NUM_PAIRS);
    localparam int ADDR_LSB    = 3;
    localparam int ADDR_WIDTH  = PAIR_IDX_W + ADDR_LSB;

    // plane coefficient: sum or difference of two entries
    localparam int COEF_W = COORD_WIDTH + 1;
    // coefficient times coordinate
    localparam int PROD_W = COEF_W + COORD_WIDTH;
    // three products plus the scaled offset, with headroom
    localparam int ACC_W  = PROD_W + 2;

    localparam int ROW_W  = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic [DATA_WIDTH-1:0]         pair_t;

    // one frustum plane: x, y, z, offset, plus a zero-normal flag
    typedef struct packed {
        logic [NUM_COEFS-1:0][COEF_W-1:0] coef;
        logic                             normal_zero;
    } plane_t;

endpackage

// File: hdl/fpbc_regs.sv
// Matrix register file on the APB-style port, and the six derived frustum planes.
// Depends on fpbc_pkg.
module fpbc_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpbc_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [fpbc_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [fpbc_pkg::DATA_WIDTH-1:0] prdata,
    output logic                            pready,
    output fpbc_pkg::plane_t                planes [fpbc_pkg::NUM_PLANES]
);

    fpbc_pkg::pair_t  matrix_reg [fpbc_pkg::NUM_PAIRS];
    fpbc_pkg::plane_t plane_reg  [fpbc_pkg::NUM_PLANES];
    fpbc_pkg::plane_t plane_next [fpbc_pkg::NUM_PLANES];

    logic                              wr_en;
    logic [fpbc_pkg::PAIR_IDX_W-1:0]   wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = paddr[fpbc_pkg::ADDR_WIDTH-1:fpbc_pkg::ADDR_LSB];
    assign prdata = matrix_reg[wr_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fpbc_pkg::NUM_PAIRS; i++)
            begin
                matrix_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            matrix_reg[wr_idx] <= pwdata;
        end
    end

    // plane k: row3 + row(k/2) when k even, row3 - row(k/2) when odd
    for (genvar k = 0; k < fpbc_pkg::NUM_PLANES; k++)
    begin : g_plane
        localparam int ROW = k / 2;
        for (genvar c = 0; c < fpbc_pkg::NUM_COEFS; c++)
        begin : g_coef
            localparam int W_PAIR = 3 * 2 + c / 2;
            localparam int E_PAIR = ROW * 2 + c / 2;
            localparam int LO     = (c % 2) * fpbc_pkg::SLOT_WIDTH;

            logic signed [fpbc_pkg::COEF_W-1:0] w_ext;
            logic signed [fpbc_pkg::COEF_W-1:0] e_ext;

            assign w_ext = fpbc_pkg::COEF_W'(
                fpbc_pkg::coord_t'(matrix_reg[W_PAIR][LO +: fpbc_pkg::COORD_WIDTH]));
            assign e_ext = fpbc_pkg::COEF_W'(
                fpbc_pkg::coord_t'(matrix_reg[E_PAIR][LO +: fpbc_pkg::COORD_WIDTH]));

            if (k % 2 == 1)
            begin : g_sub
                assign plane_next[k].coef[c] = w_ext - e_ext;
            end
            else
            begin : g_add
                assign plane_next[k].coef[c] = w_ext + e_ext;
            end
        end

        assign plane_next[k].normal_zero = (plane_next[k].coef[0] == '0)
                                        && (plane_next[k].coef[1] == '0)
                                        && (plane_next[k].coef[2] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fpbc_pkg::NUM_PLANES; i++)
            begin
                plane_reg[i] <= '{coef: '0, normal_zero: 1'b1};
            end
        end
        else
        begin
            plane_reg <= plane_next;
        end
    end

    assign planes = plane_reg;

endmodule

// File: hdl/frustum_point_box_cull.sv
// Top level of the frustum point/box cull pipeline.
// Depends on fpbc_pkg and fpbc_regs.
//
// Use:
//   Load the 4x4 view-projection matrix (Q16.16) through the APB-style port,
//   eight 64-bit registers at byte addresses 0, 8, ... 56, two entries each.
//   Then stream test items on the input channel (valid/ready): command 0 tests
//   the point first_x/y/z, command 1 tests the box first_* (min) to second_*
//   (max). Each input transfer yields exactly one output transfer carrying
//   inside_res, in order.
// Throughput: one item per cycle, sustained, when the receiver keeps up.
// Pipeline: five register stages: capture, multiply, partial sums, plane tests,
//   out. The multiply stage, 18 products of 33 x 32 bits, sets the stage depth.
// Stalls: each stage holds its item while the next is full and stalled, so
//   bubbles collapse and input is still taken while a result waits; in_ready
//   only drops once every stage is full behind a stalled output.
// Reset: clears all valid bits and the matrix to zero; with a zero matrix
//   every plane has a zero normal, so every test returns 0.
// Plane registers follow a matrix write in the cycle after it; write only while idle.
module frustum_point_box_cull
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpbc_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [fpbc_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [fpbc_pkg::DATA_WIDTH-1:0] prdata,
    output logic                            pready,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic signed [31:0]              first_x,
    input  logic signed [31:0]              first_y,
    input  logic signed [31:0]              first_z,
    input  logic signed [31:0]              second_x,
    input  logic signed [31:0]              second_y,
    input  logic signed [31:0]              second_z,
    // output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            inside_res
);

    localparam int NP = fpbc_pkg::NUM_PLANES;
    localparam int NA = fpbc_pkg::NUM_AXES;

    fpbc_pkg::plane_t planes [NP];

    fpbc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    // ---------------- stage control ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic load_s1, load_s2, load_s3, load_s4, load_out;

    // a stage loads when empty or when its content moves on
    assign load_out = !out_valid_reg || out_ready;
    assign load_s4  = !s4_valid_reg  || load_out;
    assign load_s3  = !s3_valid_reg  || load_s4;
    assign load_s2  = !s2_valid_reg  || load_s3;
    assign load_s1  = !s1_valid_reg  || load_s2;

    assign in_ready  = load_s1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_s1)  s1_valid_reg  <= in_valid;
            if (load_s2)  s2_valid_reg  <= s1_valid_reg;
            if (load_s3)  s3_valid_reg  <= s2_valid_reg;
            if (load_s4)  s4_valid_reg  <= s3_valid_reg;
            if (load_out) out_valid_reg <= s4_valid_reg;
        end
    end

    // ---------------- stage 1: capture ----------------
    fpbc_pkg::coord_t lo_in [NA];
    fpbc_pkg::coord_t hi_in [NA];
    logic             box_bad_next;

    assign lo_in[0] = first_x[fpbc_pkg::COORD_WIDTH-1:0];
    assign lo_in[1] = first_y[fpbc_pkg::COORD_WIDTH-1:0];
    assign lo_in[2] = first_z[fpbc_pkg::COORD_WIDTH-1:0];
    assign hi_in[0] = second_x[fpbc_pkg::COORD_WIDTH-1:0];
    assign hi_in[1] = second_y[fpbc_pkg::COORD_WIDTH-1:0];
    assign hi_in[2] = second_z[fpbc_pkg::COORD_WIDTH-1:0];

    // inverted box on any axis
    assign box_bad_next = (lo_in[0] > hi_in[0]) || (lo_in[1] > hi_in[1])
                       || (lo_in[2] > hi_in[2]);

    fpbc_pkg::coord_t s1_lo_reg [NA];
    fpbc_pkg::coord_t s1_hi_reg [NA];
    logic             s1_box_reg;
    logic             s1_bad_reg;

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_lo_reg  <= lo_in;
            s1_hi_reg  <= hi_in;
            s1_box_reg <= command;
            s1_bad_reg <= box_bad_next;
        end
    end

    // ---------------- stage 2: corner select and multiply ----------------
    // for a box, the corner farthest along the normal decides
    fpbc_pkg::prod_t prod_next  [NP][NA];
    fpbc_pkg::prod_t s2_prod_reg [NP][NA];
    logic            s2_box_reg;
    logic            s2_bad_reg;

    for (genvar k = 0; k < NP; k++)
    begin : g_mul
        for (genvar a = 0; a < NA; a++)
        begin : g_axis
            logic signed [fpbc_pkg::COEF_W-1:0] coef;
            fpbc_pkg::coord_t                   pick;

            assign coef = planes[k].coef[a];
            assign pick = (s1_box_reg && !coef[fpbc_pkg::COEF_W-1]) ? s1_hi_reg[a]
                                                                    : s1_lo_reg[a];
            assign prod_next[k][a] = fpbc_pkg::prod_t'(coef) * fpbc_pkg::prod_t'(pick);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s2)
        begin
            s2_prod_reg <= prod_next;
            s2_box_reg  <= s1_box_reg;
            s2_bad_reg  <= s1_bad_reg;
        end
    end

    // ---------------- stage 3: partial sums ----------------
    fpbc_pkg::acc_t sum_a_next [NP];
    fpbc_pkg::acc_t sum_b_next [NP];
    fpbc_pkg::acc_t s3_sum_a_reg [NP];
    fpbc_pkg::acc_t s3_sum_b_reg [NP];
    logic           s3_box_reg;
    logic           s3_bad_reg;

    for (genvar k = 0; k < NP; k++)
    begin : g_sum
        logic signed [fpbc_pkg::COEF_W-1:0] d_coef;
        fpbc_pkg::acc_t                     d_term;

        assign d_coef = planes[k].coef[3];
        // offset brought to the product scale
        assign d_term = fpbc_pkg::acc_t'(d_coef) <<< fpbc_pkg::FRAC_BITS;
        assign sum_a_next[k] = fpbc_pkg::acc_t'(s2_prod_reg[k][0])
                             + fpbc_pkg::acc_t'(s2_prod_reg[k][1]);
        assign sum_b_next[k] = fpbc_pkg::acc_t'(s2_prod_reg[k][2]) + d_term;
    end

    always_ff @(posedge clk)
    begin
        if (load_s3)
        begin
            s3_sum_a_reg <= sum_a_next;
            s3_sum_b_reg <= sum_b_next;
            s3_box_reg   <= s2_box_reg;
            s3_bad_reg   <= s2_bad_reg;
        end
    end

    // ---------------- stage 4: strict in-front test per plane ----------------
    logic [NP-1:0] pass_next;
    logic [NP-1:0] s4_pass_reg;
    logic          s4_reject_reg;

    for (genvar k = 0; k < NP; k++)
    begin : g_test
        fpbc_pkg::acc_t total;

        assign total = s3_sum_a_reg[k] + s3_sum_b_reg[k];
        // on the plane counts as behind; a zero normal fails everything
        assign pass_next[k] = !planes[k].normal_zero
                           && !total[fpbc_pkg::ACC_W-1] && (total != '0);
    end

    always_ff @(posedge clk)
    begin
        if (load_s4)
        begin
            s4_pass_reg   <= pass_next;
            s4_reject_reg <= s3_box_reg && s3_bad_reg;
        end
    end

    // ---------------- output register ----------------
    logic inside_reg;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            inside_reg <= (&s4_pass_reg) && !s4_reject_reg;
        end
    end

    assign inside_res = inside_reg;

endmodule

// File: hdl/fpbc_checker.sv
// Port-level checks for frustum_point_box_cull, bound to the top level.
// Depends on fpbc_pkg.
module fpbc_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [fpbc_pkg::ADDR_WIDTH-1:0] paddr,
    input logic [fpbc_pkg::DATA_WIDTH-1:0] pwdata,
    input logic [fpbc_pkg::DATA_WIDTH-1:0] prdata,
    input logic                            pready,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            inside_res
);

    // nothing leaves while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inside_res))
        else $error("stalled result changed or vanished");

    // input back-pressure only when the whole pipe is full behind a stalled output
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without an output stall");

    // a register reads back what was just written
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready)
        ##1 (paddr[fpbc_pkg::ADDR_WIDTH-1:fpbc_pkg::ADDR_LSB]
             == $past(paddr[fpbc_pkg::ADDR_WIDTH-1:fpbc_pkg::ADDR_LSB]))
        |-> prdata == $past(pwdata))
        else $error("register read-back mismatch");

endmodule

bind frustum_point_box_cull fpbc_checker u_fpbc_checker (.*);

// File: tb/fpbc_tb_pkg.sv
`timescale 1ns / 100ps
// Command codes and fixed-point constants shared by the cull testbench files.
// Depends on fpbc_pkg only; compile it before the checker and the testbench top.
package fpbc_tb_pkg;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_BOX   = 1'b1;

    localparam int PAIRS_PER_ROW = 2;
    localparam int MATRIX_DIM    = 4;
    localparam int Q_ONE         = 1 << fpbc_pkg::FRAC_BITS;

    localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] COORD_MIN = 32'h8000_0000;

endpackage

// File: tb/frustum_point_box_cull_checker.sv
`timescale 1ns / 100ps
// Scoreboard for frustum_point_box_cull: mirrors the matrix from the APB port,
// predicts inside_res for every input transfer and checks each output transfer.
// Depends on fpbc_pkg and fpbc_tb_pkg.
module frustum_point_box_cull_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpbc_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [fpbc_pkg::DATA_WIDTH-1:0] pwdata,
    input  logic [fpbc_pkg::DATA_WIDTH-1:0] prdata,
    input  logic                            pready,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            command,
    input  logic signed [31:0]              first_x,
    input  logic signed [31:0]              first_y,
    input  logic signed [31:0]              first_z,
    input  logic signed [31:0]              second_x,
    input  logic signed [31:0]              second_y,
    input  logic signed [31:0]              second_z,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            inside_res,
    output int                              mismatch_count,
    output int                              results_pending,
    output int                              results_checked
);

    localparam int REPORT_LINES = 100;

    fpbc_pkg::pair_t                   matrix_copy [fpbc_pkg::NUM_PAIRS];
    logic [fpbc_pkg::PAIR_IDX_W-1:0]   pair_sel;
    logic                              inside_expected [$];
    logic                              inside_wanted;
    int                                fail_tally;
    int                                checked_tally;

    assign pair_sel = paddr[fpbc_pkg::ADDR_WIDTH-1:fpbc_pkg::ADDR_LSB];

    task automatic report_mismatch(input string what);
        fail_tally++;
        if (fail_tally <= REPORT_LINES)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // one sign-extended Q16.16 matrix entry from the mirrored registers
    function automatic logic signed [63:0] entry_of(input int row, input int col);
        fpbc_pkg::pair_t                          pr;
        logic signed [fpbc_pkg::COORD_WIDTH-1:0]  half;
        logic signed [63:0]                       wide;
        pr   = matrix_copy[row * fpbc_tb_pkg::PAIRS_PER_ROW + col / 2];
        half = pr[(col % 2) * fpbc_pkg::SLOT_WIDTH +: fpbc_pkg::COORD_WIDTH];
        wide = half;
        return wide;
    endfunction

    // exact a*x + b*y + c*z + d > 0, with d lifted to the product scale
    function automatic logic strictly_in_front(input logic [3:0][63:0] cf,
                                               input logic [2:0][31:0] pt);
        logic signed [127:0] acc;
        logic signed [127:0] lhs;
        logic signed [127:0] rhs;
        if (cf[0] == '0 && cf[1] == '0 && cf[2] == '0)
            return 1'b0;
        acc = '0;
        for (int c = 0; c < fpbc_pkg::NUM_AXES; c++)
        begin
            lhs = $signed(cf[c]);
            rhs = $signed(pt[c]);
            acc = acc + lhs * rhs;
        end
        lhs = $signed(cf[3]);
        acc = acc + (lhs <<< fpbc_pkg::FRAC_BITS);
        return acc > 0;
    endfunction

    function automatic logic cull_verdict(input logic box,
                                          input logic [2:0][31:0] lo,
                                          input logic [2:0][31:0] hi);
        logic [3:0][63:0]    cf;
        logic [2:0][31:0]    probe;
        logic signed [63:0]  w;
        logic signed [63:0]  e;
        logic                keep;
        keep = 1'b1;
        if (box)
            for (int c = 0; c < fpbc_pkg::NUM_AXES; c++)
                if ($signed(lo[c]) > $signed(hi[c]))
                    keep = 1'b0;
        // planes: row3 + row_k/2 for even k, row3 - row_k/2 for odd k
        for (int k = 0; k < fpbc_pkg::NUM_PLANES && keep; k++)
        begin
            for (int c = 0; c < fpbc_pkg::NUM_COEFS; c++)
            begin
                w = entry_of(fpbc_tb_pkg::MATRIX_DIM - 1, c);
                e = entry_of(k / 2, c);
                cf[c] = (k % 2 == 1) ? w - e : w + e;
            end
            // box: the corner furthest along the normal decides
            for (int c = 0; c < fpbc_pkg::NUM_AXES; c++)
                probe[c] = !box ? lo[c] : ($signed(cf[c]) >= 0 ? hi[c] : lo[c]);
            if (!strictly_in_front(cf, probe))
                keep = 1'b0;
        end
        return keep;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            foreach (matrix_copy[i])
                matrix_copy[i] = '0;
            inside_expected.delete();
            fail_tally      = 0;
            checked_tally   = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                    matrix_copy[pair_sel] = pwdata;
                else if (prdata !== matrix_copy[pair_sel])
                    report_mismatch($sformatf("pair %0d read back %h, expected %h",
                        pair_sel, prdata, matrix_copy[pair_sel]));
            end
            if (out_valid && out_ready)
            begin
                if (inside_expected.size() == 0)
                    report_mismatch($sformatf("result %b with no test outstanding",
                        inside_res));
                else
                begin
                    inside_wanted = inside_expected.pop_front();
                    checked_tally++;
                    if (inside_res !== inside_wanted)
                        report_mismatch($sformatf("result %0d: inside_res %b, expected %b",
                            checked_tally, inside_res, inside_wanted));
                end
            end
            if (in_valid && in_ready)
                inside_expected.push_back(cull_verdict(command == fpbc_tb_pkg::CMD_BOX,
                    {first_z, first_y, first_x}, {second_z, second_y, second_x}));
        end
        mismatch_count  <= fail_tally;
        results_pending <= inside_expected.size();
        results_checked <= checked_tally;
    end

endmodule

// File: tb/frustum_point_box_cull_tb.sv
`timescale 1ns / 100ps
// Testbench top for frustum_point_box_cull: loads matrices over APB, streams
// point and box tests with random idling on both sides, and gives the verdict.
// Depends on fpbc_pkg, fpbc_tb_pkg, frustum_point_box_cull_checker and the RTL.
module frustum_point_box_cull_tb;

    localparam int CLK_HALF_NS        = 5;
    localparam int RESET_CYCLES       = 9;
    // pipeline is five stages deep; planes follow a matrix write in the next cycle
    localparam int SETTLE_CYCLES      = 8;
    localparam int ITEMS_PER_PHASE    = 200;
    localparam int RANDOM_PHASES      = 5;
    localparam int NOISE_PHASE        = 2;
    localparam int DRAIN_PHASE        = 3;
    localparam int BURST_SPAN         = 50;
    localparam int HOLD_AFTER_RESULTS = 300;
    localparam int LONG_HOLD_CYCLES   = 80;
    // run time limit in ns; reaching it ends the run as a failure
    localparam int LIMIT_NS           = 5_000_000;

    typedef struct packed {
        logic             box;
        logic [2:0][31:0] lo;
        logic [2:0][31:0] hi;
    } cull_item_t;

    logic                            clk;
    logic                            rst_n    = 1'b0;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [fpbc_pkg::ADDR_WIDTH-1:0] paddr    = '0;
    logic [fpbc_pkg::DATA_WIDTH-1:0] pwdata   = '0;
    logic [fpbc_pkg::DATA_WIDTH-1:0] prdata;
    logic                            pready;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic                            command  = fpbc_tb_pkg::CMD_POINT;
    logic signed [31:0]              first_x  = '0;
    logic signed [31:0]              first_y  = '0;
    logic signed [31:0]              first_z  = '0;
    logic signed [31:0]              second_x = '0;
    logic signed [31:0]              second_y = '0;
    logic signed [31:0]              second_z = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            inside_res;

    int mismatch_count;
    int results_pending;
    int results_checked;

    // Q16.16 matrix image, [row][column], committed by commit_matrix
    logic [31:0] matrix_entry [fpbc_tb_pkg::MATRIX_DIM][fpbc_tb_pkg::MATRIX_DIM];
    logic        burst = 1'b0;      // sender offers back to back while set
    int          points_sent;
    int          boxes_sent;
    int          matrices_loaded;

    frustum_point_box_cull uut (.*);

    frustum_point_box_cull_checker cull_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("run limit reached with %0d results outstanding", results_pending);
        $display("end of test: mismatches");
        $finish;
    end

    // mostly no idling, some short gaps, the odd long one
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    // coordinates clustered round the unit frustum, plus noise and extremes
    function automatic logic [31:0] pick_coord();
        int roll;
        int span;
        roll = $urandom_range(0, 99);
        span = 3 * fpbc_tb_pkg::Q_ONE;
        if (roll < 65)
            return $urandom_range(0, 2 * span) - span;
        else if (roll < 80)
            return $urandom();
        else if (roll < 90)
            return $urandom_range(0, 511) - 256;
        else
            case ($urandom_range(0, 5))
                0:       return fpbc_tb_pkg::COORD_MAX;
                1:       return fpbc_tb_pkg::COORD_MIN;
                2:       return '0;
                3:       return fpbc_tb_pkg::Q_ONE;
                4:       return -fpbc_tb_pkg::Q_ONE;
                default: return 32'hFFFF_FFFF;
            endcase
    endfunction

    function automatic cull_item_t make_item();
        cull_item_t  item;
        logic [31:0] a;
        logic [31:0] b;
        int          shape;
        item.box = ($urandom_range(0, 1) == 1) ? fpbc_tb_pkg::CMD_BOX
                                                : fpbc_tb_pkg::CMD_POINT;
        shape    = $urandom_range(0, 99);
        for (int c = 0; c < fpbc_pkg::NUM_AXES; c++)
        begin
            a = pick_coord();
            b = pick_coord();
            // most boxes well formed; the rest keep whatever order came out
            if (item.box == fpbc_tb_pkg::CMD_BOX && shape < 80)
            begin
                if ($signed(a) > $signed(b))
                    {a, b} = {b, a};
                if (shape < 8)
                    b = a;
            end
            item.lo[c] = a;
            item.hi[c] = b;
        end
        return item;
    endfunction

    function automatic cull_item_t item_of(input logic box,
                                           input logic [31:0] lx, ly, lz,
                                           input logic [31:0] hx, hy, hz);
        cull_item_t item;
        item.box = box;
        item.lo  = {lz, ly, lx};
        item.hi  = {hz, hy, hx};
        return item;
    endfunction

    function automatic void set_row(input int r, input logic [31:0] a, b, c, d);
        matrix_entry[r][0] = a;
        matrix_entry[r][1] = b;
        matrix_entry[r][2] = c;
        matrix_entry[r][3] = d;
    endfunction

    function automatic int jitter(input int amount);
        return $urandom_range(0, 2 * amount) - amount;
    endfunction

    // rows 0..2 roughly diagonal, w row near (0, 0, 0, 1): a sane frustum
    function automatic void random_frustum_matrix();
        int scale;
        for (int r = 0; r < fpbc_tb_pkg::MATRIX_DIM - 1; r++)
        begin
            for (int c = 0; c < fpbc_tb_pkg::MATRIX_DIM; c++)
                matrix_entry[r][c] = jitter(fpbc_tb_pkg::Q_ONE / 8);
            scale = $urandom_range(fpbc_tb_pkg::Q_ONE / 2, 2 * fpbc_tb_pkg::Q_ONE);
            matrix_entry[r][r] = ($urandom_range(0, 1) == 1) ? scale : -scale;
        end
        for (int c = 0; c < fpbc_tb_pkg::MATRIX_DIM - 1; c++)
            matrix_entry[fpbc_tb_pkg::MATRIX_DIM - 1][c] = jitter(fpbc_tb_pkg::Q_ONE / 16);
        matrix_entry[fpbc_tb_pkg::MATRIX_DIM - 1][fpbc_tb_pkg::MATRIX_DIM - 1] =
            fpbc_tb_pkg::Q_ONE + jitter(fpbc_tb_pkg::Q_ONE / 4);
    endfunction

    function automatic void raw_random_matrix();
        foreach (matrix_entry[r, c])
            matrix_entry[r][c] = $urandom();
    endfunction

    // one APB transfer; psel stays up so transfers can run back to back
    task automatic apb_transfer(input logic is_write, input int pair_index,
                                input fpbc_pkg::pair_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= fpbc_pkg::ADDR_WIDTH'(pair_index << fpbc_pkg::ADDR_LSB);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // write all eight pairs, read them back, let the new planes settle
    task automatic commit_matrix();
        fpbc_pkg::pair_t image [fpbc_pkg::NUM_PAIRS];
        for (int r = 0; r < fpbc_tb_pkg::MATRIX_DIM; r++)
        begin
            image[r * fpbc_tb_pkg::PAIRS_PER_ROW]     = {matrix_entry[r][1],
                                                         matrix_entry[r][0]};
            image[r * fpbc_tb_pkg::PAIRS_PER_ROW + 1] = {matrix_entry[r][3],
                                                         matrix_entry[r][2]};
        end
        for (int i = 0; i < fpbc_pkg::NUM_PAIRS; i++)
            apb_transfer(1'b1, i, image[i]);
        for (int i = 0; i < fpbc_pkg::NUM_PAIRS; i++)
            apb_transfer(1'b0, i, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        matrices_loaded++;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // hold valid until the transfer; a zero gap keeps valid high throughout
    task automatic offer(input cull_item_t item);
        int gap;
        gap = burst ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= item.box;
        first_x  <= item.lo[0];
        first_y  <= item.lo[1];
        first_z  <= item.lo[2];
        second_x <= item.hi[0];
        second_y <= item.hi[1];
        second_z <= item.hi[2];
        do @(posedge clk); while (!in_ready);
        if (item.box == fpbc_tb_pkg::CMD_BOX)
            boxes_sent++;
        else
            points_sent++;
    endtask

    // stop offering until every outstanding result is out, then let it settle
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // output side: random stalls, stretches of full readiness, one long hold
    initial
    begin : result_sink
        int   hold;
        logic long_hold_done;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && results_checked >= HOLD_AFTER_RESULTS && in_valid)
            begin
                // pipeline fills behind the stall and in_ready has to drop
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                hold = idle_len();
                out_ready <= (hold == 0);
                repeat ((hold == 0) ? 1 : hold) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // matrix still zero after reset: every normal is zero, all culled
        offer(item_of(fpbc_tb_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0));
        offer(item_of(fpbc_tb_pkg::CMD_BOX, -fpbc_tb_pkg::Q_ONE, -fpbc_tb_pkg::Q_ONE,
                      -fpbc_tb_pkg::Q_ONE, fpbc_tb_pkg::Q_ONE, fpbc_tb_pkg::Q_ONE,
                      fpbc_tb_pkg::Q_ONE));
        drain_results();

        // unit cube: inside means |x|, |y|, |z| < 1
        set_row(0, fpbc_tb_pkg::Q_ONE, 0, 0, 0);
        set_row(1, 0, fpbc_tb_pkg::Q_ONE, 0, 0);
        set_row(2, 0, 0, fpbc_tb_pkg::Q_ONE, 0);
        set_row(3, 0, 0, 0, fpbc_tb_pkg::Q_ONE);
        commit_matrix();
        // centre; the box fields are don't-care for a point
        offer(item_of(fpbc_tb_pkg::CMD_POINT, 0, 0, 0, fpbc_tb_pkg::COORD_MAX,
                      fpbc_tb_pkg::COORD_MIN, 32'hFFFF_FFFF));
        // exactly on a plane counts as behind it
        offer(item_of(fpbc_tb_pkg::CMD_POINT, fpbc_tb_pkg::Q_ONE, 0, 0, 0, 0, 0));
        offer(item_of(fpbc_tb_pkg::CMD_POINT, 0, 0, -fpbc_tb_pkg::Q_ONE, 0, 0, 0));
        offer(item_of(fpbc_tb_pkg::CMD_POINT, fpbc_tb_pkg::Q_ONE - 1,
                      1 - fpbc_tb_pkg::Q_ONE, fpbc_tb_pkg::Q_ONE - 1, 0, 0, 0));
        offer(item_of(fpbc_tb_pkg::CMD_POINT, fpbc_tb_pkg::COORD_MAX,
                      fpbc_tb_pkg::COORD_MIN, 0, 0, 0, 0));
        offer(item_of(fpbc_tb_pkg::CMD_BOX, -2 * fpbc_tb_pkg::Q_ONE,
                      -2 * fpbc_tb_pkg::Q_ONE, -2 * fpbc_tb_pkg::Q_ONE,
                      2 * fpbc_tb_pkg::Q_ONE, 2 * fpbc_tb_pkg::Q_ONE,
                      2 * fpbc_tb_pkg::Q_ONE));
        // only touches the right plane
        offer(item_of(fpbc_tb_pkg::CMD_BOX, fpbc_tb_pkg::Q_ONE, -fpbc_tb_pkg::Q_ONE / 2,
                      -fpbc_tb_pkg::Q_ONE / 2, 2 * fpbc_tb_pkg::Q_ONE,
                      fpbc_tb_pkg::Q_ONE / 2, fpbc_tb_pkg::Q_ONE / 2));
        // inverted on x, then on z
        offer(item_of(fpbc_tb_pkg::CMD_BOX, fpbc_tb_pkg::Q_ONE / 2, 0, 0,
                      -fpbc_tb_pkg::Q_ONE / 2, fpbc_tb_pkg::Q_ONE / 4,
                      fpbc_tb_pkg::Q_ONE / 4));
        offer(item_of(fpbc_tb_pkg::CMD_BOX, 0, 0, fpbc_tb_pkg::Q_ONE / 2,
                      fpbc_tb_pkg::Q_ONE / 4, fpbc_tb_pkg::Q_ONE / 4,
                      -fpbc_tb_pkg::Q_ONE / 2));
        offer(item_of(fpbc_tb_pkg::CMD_BOX, 0, 0, 0, 0, 0, 0));
        offer(item_of(fpbc_tb_pkg::CMD_BOX, fpbc_tb_pkg::COORD_MIN, fpbc_tb_pkg::COORD_MIN,
                      fpbc_tb_pkg::COORD_MIN, fpbc_tb_pkg::COORD_MAX,
                      fpbc_tb_pkg::COORD_MAX, fpbc_tb_pkg::COORD_MAX));
        offer(item_of(fpbc_tb_pkg::CMD_BOX, fpbc_tb_pkg::COORD_MAX, fpbc_tb_pkg::COORD_MAX,
                      fpbc_tb_pkg::COORD_MAX, fpbc_tb_pkg::COORD_MAX,
                      fpbc_tb_pkg::COORD_MAX, fpbc_tb_pkg::COORD_MAX));
        drain_results();

        // row3 - row0 has a zero normal: nothing can pass
        set_row(0, fpbc_tb_pkg::Q_ONE / 2, 0, 0, 0);
        set_row(3, fpbc_tb_pkg::Q_ONE / 2, 0, 0, fpbc_tb_pkg::Q_ONE);
        commit_matrix();
        offer(item_of(fpbc_tb_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0));
        offer(item_of(fpbc_tb_pkg::CMD_BOX, -fpbc_tb_pkg::Q_ONE, -fpbc_tb_pkg::Q_ONE,
                      -fpbc_tb_pkg::Q_ONE, fpbc_tb_pkg::Q_ONE, fpbc_tb_pkg::Q_ONE,
                      fpbc_tb_pkg::Q_ONE));
        drain_results();

        // full-scale entries: widest coefficients and products
        set_row(0, fpbc_tb_pkg::COORD_MAX, fpbc_tb_pkg::COORD_MIN,
                fpbc_tb_pkg::COORD_MAX, fpbc_tb_pkg::COORD_MIN);
        set_row(1, fpbc_tb_pkg::COORD_MIN, fpbc_tb_pkg::COORD_MIN,
                fpbc_tb_pkg::COORD_MAX, fpbc_tb_pkg::COORD_MAX);
        set_row(2, fpbc_tb_pkg::COORD_MAX, fpbc_tb_pkg::COORD_MAX,
                fpbc_tb_pkg::COORD_MAX, fpbc_tb_pkg::COORD_MAX);
        set_row(3, fpbc_tb_pkg::COORD_MIN, fpbc_tb_pkg::COORD_MAX,
                fpbc_tb_pkg::COORD_MIN, fpbc_tb_pkg::COORD_MAX);
        commit_matrix();
        offer(item_of(fpbc_tb_pkg::CMD_POINT, fpbc_tb_pkg::COORD_MAX,
                      fpbc_tb_pkg::COORD_MIN, fpbc_tb_pkg::COORD_MAX, 0, 0, 0));
        offer(item_of(fpbc_tb_pkg::CMD_POINT, fpbc_tb_pkg::COORD_MIN,
                      fpbc_tb_pkg::COORD_MIN, fpbc_tb_pkg::COORD_MIN, 0, 0, 0));
        offer(item_of(fpbc_tb_pkg::CMD_BOX, fpbc_tb_pkg::COORD_MIN, fpbc_tb_pkg::COORD_MIN,
                      fpbc_tb_pkg::COORD_MIN, fpbc_tb_pkg::COORD_MAX,
                      fpbc_tb_pkg::COORD_MAX, fpbc_tb_pkg::COORD_MAX));
        offer(item_of(fpbc_tb_pkg::CMD_BOX, -1, -1, -1, 1, 1, 1));
        drain_results();

        // random phases; one with a fully random matrix as noise
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == NOISE_PHASE)
                raw_random_matrix();
            else
                random_frustum_matrix();
            commit_matrix();
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % BURST_SPAN == 0)
                    burst = ($urandom_range(0, 3) == 0);
                // mid-stream pause until the pipeline is empty
                if (phase == DRAIN_PHASE && n == ITEMS_PER_PHASE / 2)
                    drain_results();
                offer(make_item());
            end
            drain_results();
        end

        $display("covered %0d point tests and %0d box tests over %0d matrix settings",
                 points_sent, boxes_sent, matrices_loaded);
        $display("%0d results checked, with a long output hold and a mid-stream drain",
                 results_checked);
        if (mismatch_count == 0 && results_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
